### rtl/core/serial_clock_chip_command_shift_unit_defines.svh
// ----------------------------------------------------------------------------
// serial clock chip command shift unit - assertion macros
// shared property wrappers for the concurrent checks of the unit
// ----------------------------------------------------------------------------
`ifndef SERIAL_CLOCK_CHIP_COMMAND_SHIFT_UNIT_DEFINES_SVH
`define SERIAL_CLOCK_CHIP_COMMAND_SHIFT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SCCSU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SCCSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sccsu_pkg.sv
// ----------------------------------------------------------------------------
// sccsu_pkg
// op codes, command modes, pin indexes and divider limits of the unit
// ----------------------------------------------------------------------------
package sccsu_pkg;

    // counter and shift register geometry
    localparam int BYTE_N = 5;
    localparam int TIME_W = 8 * BYTE_N;

    // request op codes
    localparam logic [3:0] OP_OE    = 4'd0;
    localparam logic [3:0] OP_CS    = 4'd1;
    localparam logic [3:0] OP_STB   = 4'd2;
    localparam logic [3:0] OP_CLK   = 4'd3;
    localparam logic [3:0] OP_C0    = 4'd4;
    localparam logic [3:0] OP_C1    = 4'd5;
    localparam logic [3:0] OP_C2    = 4'd6;
    localparam logic [3:0] OP_DIN   = 4'd7;
    localparam logic [3:0] OP_TICK  = 4'd8;

    // latched command modes
    localparam logic [2:0] MODE_HOLD     = 3'd0;
    localparam logic [2:0] MODE_SERIAL   = 3'd1;
    localparam logic [2:0] MODE_TIME_WR  = 3'd2;
    localparam logic [2:0] MODE_TIME_RD  = 3'd3;
    localparam logic [2:0] MODE_TP_64    = 3'd4;
    localparam logic [2:0] MODE_TP_256   = 3'd5;
    localparam logic [2:0] MODE_TP_2048  = 3'd6;
    localparam logic [2:0] MODE_CNT_TEST = 3'd7;

    // pin level bit positions
    localparam int PIN_OE  = 0;
    localparam int PIN_CS  = 1;
    localparam int PIN_STB = 2;
    localparam int PIN_CLK = 3;
    localparam int PIN_DIN = 4;

    // tp rate selects
    localparam logic [1:0] TP_SEL_64   = 2'd0;
    localparam logic [1:0] TP_SEL_32   = 2'd1;
    localparam logic [1:0] TP_SEL_256  = 2'd2;
    localparam logic [1:0] TP_SEL_2048 = 2'd3;

    // data-out wave half periods in ticks
    localparam logic [11:0] PULSE_SLOW_LIMIT = 12'd2048;
    localparam logic [11:0] PULSE_FAST_LIMIT = 12'd4;

    // tp half period in ticks for a rate select
    function automatic logic [6:0] tp_limit(input logic [1:0] sel);
        logic [6:0] lim;
        unique case (sel)
            TP_SEL_64:   lim = 7'd32;
            TP_SEL_32:   lim = 7'd64;
            TP_SEL_256:  lim = 7'd8;
            TP_SEL_2048: lim = 7'd1;
            default:     lim = 7'd1;
        endcase
        return lim;
    endfunction

endpackage

### rtl/core/serial_clock_chip_command_shift_unit.sv
// ----------------------------------------------------------------------------
// serial_clock_chip_command_shift_unit
// pin events and time-base ticks drive the command latch, the 40-bit shift
// register, the square-wave dividers and the test-mode counter
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    op[3:0], value
//  output    out_valid / out_ready  data_out, tp
//
//  one request per cycle sustained while out_ready is high; an accepted request
//  goes through the input register and then the result register
//  all state updates when a request moves from the input register to the
//  result register, through one pass of shift, increment and divider logic
//  a stalled result holds the pipe; in_ready stays high while the input
//  register is empty or moving on
//  reset (rst_n low, async) clears pins, command, counters and both dividers
// ----------------------------------------------------------------------------
`include "serial_clock_chip_command_shift_unit_defines.svh"

module serial_clock_chip_command_shift_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] op,
    input  logic       value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       data_out,
    output logic       tp
);
    import sccsu_pkg::*;

    // pipeline registers
    logic              in_valid_reg;
    logic [3:0]        op_reg;
    logic              value_reg;
    logic              out_valid_reg;
    logic              data_out_reg;
    logic              tp_out_reg;
    logic              advance;

    // unit state
    logic [TIME_W-1:0] time_count_reg,  time_count_next;
    logic [TIME_W-1:0] shift_reg,       shift_next;
    logic [2:0]        mode_reg,        mode_next;
    logic [2:0]        pending_reg,     pending_next;
    logic [4:0]        pins_reg,        pins_next;
    logic              dout_reg,        dout_next;
    logic              tp_level_reg,    tp_level_next;
    logic              tp_run_reg,      tp_run_next;
    logic [1:0]        tp_sel_reg,      tp_sel_next;
    logic [5:0]        tp_phase_reg,    tp_phase_next;
    logic              pulse_run_reg,   pulse_run_next;
    logic              pulse_fast_reg,  pulse_fast_next;
    logic [10:0]       pulse_phase_reg, pulse_phase_next;
    logic [1:0]        test_phase_reg,  test_phase_next;

    // test counter step
    logic [TIME_W-1:0] test_count_next;
    logic              test_dout_next;

    logic [6:0]        tp_sum;
    logic [11:0]       pulse_sum;
    logic [11:0]       pulse_lim;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign tp        = tp_out_reg;

    sccsu_test_count u_test_count (
        .count      (time_count_reg),
        .carry_mode (pins_reg[PIN_OE]),
        .count_next (test_count_next),
        .dout_next  (test_dout_next)
    );

    assign tp_sum    = {1'b0, tp_phase_reg} + 7'd1;
    assign pulse_sum = {1'b0, pulse_phase_reg} + 12'd1;
    assign pulse_lim = pulse_fast_reg ? PULSE_FAST_LIMIT : PULSE_SLOW_LIMIT;

    // next state for the request in the input register
    always_comb
    begin
        time_count_next  = time_count_reg;
        shift_next       = shift_reg;
        mode_next        = mode_reg;
        pending_next     = pending_reg;
        pins_next        = pins_reg;
        dout_next        = dout_reg;
        tp_level_next    = tp_level_reg;
        tp_run_next      = tp_run_reg;
        tp_sel_next      = tp_sel_reg;
        tp_phase_next    = tp_phase_reg;
        pulse_run_next   = pulse_run_reg;
        pulse_fast_next  = pulse_fast_reg;
        pulse_phase_next = pulse_phase_reg;
        test_phase_next  = test_phase_reg;

        unique case (op_reg)
            OP_OE:  pins_next[PIN_OE]  = value_reg;
            OP_CS:  pins_next[PIN_CS]  = value_reg;
            OP_DIN: pins_next[PIN_DIN] = value_reg;
            OP_C0:  pending_next[0]    = value_reg;
            OP_C1:  pending_next[1]    = value_reg;
            OP_C2:  pending_next[2]    = value_reg;

            // strobe high with cs high and clk low latches the pending command
            OP_STB:
            begin
                pins_next[PIN_STB] = value_reg;
                if (pins_reg[PIN_CS] && value_reg && !pins_reg[PIN_CLK])
                begin
                    mode_next = pending_reg;
                    unique case (pending_reg)
                        MODE_HOLD:
                        begin
                            dout_next        = 1'b1;
                            pulse_run_next   = 1'b1;
                            pulse_fast_next  = 1'b0;
                            pulse_phase_next = '0;
                            tp_run_next      = 1'b1;
                            tp_sel_next      = TP_SEL_64;
                            tp_phase_next    = '0;
                        end
                        MODE_SERIAL:
                        begin
                            pulse_run_next = 1'b0;
                            dout_next      = shift_reg[0];
                            tp_run_next    = 1'b1;
                            tp_sel_next    = TP_SEL_32;
                            tp_phase_next  = '0;
                        end
                        MODE_TIME_WR:
                        begin
                            pulse_run_next  = 1'b0;
                            dout_next       = shift_reg[0];
                            time_count_next = shift_reg;
                            tp_run_next     = 1'b1;
                            tp_sel_next     = TP_SEL_32;
                            tp_phase_next   = '0;
                        end
                        MODE_TIME_RD:
                        begin
                            shift_next       = time_count_reg;
                            dout_next        = 1'b1;
                            pulse_run_next   = 1'b1;
                            pulse_fast_next  = 1'b1;
                            pulse_phase_next = '0;
                            tp_run_next      = 1'b1;
                            tp_sel_next      = TP_SEL_32;
                            tp_phase_next    = '0;
                        end
                        MODE_TP_64:
                        begin
                            tp_run_next   = 1'b1;
                            tp_sel_next   = TP_SEL_64;
                            tp_phase_next = '0;
                        end
                        MODE_TP_256:
                        begin
                            tp_run_next   = 1'b1;
                            tp_sel_next   = TP_SEL_256;
                            tp_phase_next = '0;
                        end
                        MODE_TP_2048:
                        begin
                            tp_run_next   = 1'b1;
                            tp_sel_next   = TP_SEL_2048;
                            tp_phase_next = '0;
                        end
                        MODE_CNT_TEST:
                        begin
                            pulse_run_next  = 1'b0;
                            test_phase_next = '0;
                        end
                        default:
                        begin
                            pulse_run_next = pulse_run_reg;
                        end
                    endcase
                end
            end

            // rising clock in shift mode moves the register one place down
            OP_CLK:
            begin
                pins_next[PIN_CLK] = value_reg;
                if (!pins_reg[PIN_CLK] && value_reg && (mode_reg == MODE_SERIAL))
                begin
                    shift_next = {pins_reg[PIN_DIN], shift_reg[TIME_W-1:1]};
                    if (pins_reg[PIN_OE])
                    begin
                        dout_next = shift_reg[1];
                    end
                end
            end

            // time base: tp divider, data-out wave, test counter
            OP_TICK:
            begin
                if (tp_run_reg)
                begin
                    if (tp_sum >= tp_limit(tp_sel_reg))
                    begin
                        tp_phase_next = '0;
                        tp_level_next = !tp_level_reg;
                    end
                    else
                    begin
                        tp_phase_next = tp_sum[5:0];
                    end
                end
                if (pulse_run_reg)
                begin
                    if (pulse_sum >= pulse_lim)
                    begin
                        pulse_phase_next = '0;
                        dout_next        = !dout_reg;
                    end
                    else
                    begin
                        pulse_phase_next = pulse_sum[10:0];
                    end
                end
                if (mode_reg == MODE_CNT_TEST)
                begin
                    test_phase_next = test_phase_reg + 2'd1;
                    if (test_phase_reg == 2'd3)
                    begin
                        time_count_next = test_count_next;
                        dout_next       = test_dout_next;
                    end
                end
            end

            default:
            begin
                pins_next = pins_reg;
            end
        endcase
    end

    // input register and result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (advance)
        begin
            data_out_reg <= dout_next;
            tp_out_reg   <= tp_level_next;
        end
    end

    // unit state, updated as each request passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_count_reg  <= '0;
            shift_reg       <= '0;
            mode_reg        <= MODE_HOLD;
            pending_reg     <= '0;
            pins_reg        <= '0;
            dout_reg        <= 1'b0;
            tp_level_reg    <= 1'b0;
            tp_run_reg      <= 1'b0;
            tp_sel_reg      <= TP_SEL_64;
            tp_phase_reg    <= '0;
            pulse_run_reg   <= 1'b0;
            pulse_fast_reg  <= 1'b0;
            pulse_phase_reg <= '0;
            test_phase_reg  <= '0;
        end
        else if (advance)
        begin
            time_count_reg  <= time_count_next;
            shift_reg       <= shift_next;
            mode_reg        <= mode_next;
            pending_reg     <= pending_next;
            pins_reg        <= pins_next;
            dout_reg        <= dout_next;
            tp_level_reg    <= tp_level_next;
            tp_run_reg      <= tp_run_next;
            tp_sel_reg      <= tp_sel_next;
            tp_phase_reg    <= tp_phase_next;
            pulse_run_reg   <= pulse_run_next;
            pulse_fast_reg  <= pulse_fast_next;
            pulse_phase_reg <= pulse_phase_next;
            test_phase_reg  <= test_phase_next;
        end
    end

    // checks
    `SCCSU_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, out_valid_reg,
        "request lost between stages")
    `SCCSU_ASSERT_IMPL(a_tp_phase_bound, clk, rst_n, tp_run_reg,
        ({1'b0, tp_phase_reg} < tp_limit(tp_sel_reg)), "tp divider phase out of range")
    `SCCSU_ASSERT_IMPL(a_pulse_phase_bound, clk, rst_n, pulse_run_reg,
        ({1'b0, pulse_phase_reg} < pulse_lim), "data-out divider phase out of range")
    `SCCSU_ASSERT_NEXT(a_test_phase_idle, clk, rst_n, (mode_reg != MODE_CNT_TEST),
        ((mode_reg == MODE_CNT_TEST) || $stable(test_phase_reg)),
        "test phase moved outside test mode")

endmodule

### rtl/core/sccsu_test_count.sv
// ----------------------------------------------------------------------------
// sccsu_test_count
// test-mode step of the 40-bit time counter: full carry or per-byte count
// ----------------------------------------------------------------------------
module sccsu_test_count (
    input  logic [sccsu_pkg::TIME_W-1:0] count,
    input  logic                         carry_mode,
    output logic [sccsu_pkg::TIME_W-1:0] count_next,
    output logic                         dout_next
);
    import sccsu_pkg::*;

    logic [TIME_W-1:0] count_carry;
    logic [TIME_W-1:0] count_bytes;

    // whole word increment, carry runs through all bytes
    assign count_carry = count + TIME_W'(1);

    // every byte counts on its own
    always_comb
    begin
        for (int i = 0; i < BYTE_N; i++)
        begin
            count_bytes[8*i +: 8] = count[8*i +: 8] + 8'd1;
        end
    end

    // carry mode samples the top byte before the count, byte mode after it
    always_comb
    begin
        if (carry_mode)
        begin
            count_next = count_carry;
            dout_next  = (count[TIME_W-1 -: 8] == 8'd0);
        end
        else
        begin
            count_next = count_bytes;
            dout_next  = (count_bytes[TIME_W-1 -: 8] == 8'd0);
        end
    end

endmodule

### bench/serial_clock_chip_command_shift_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_clock_chip_command_shift_unit_tb
// drives pin writes and time-base ticks through the request channel and
// checks every data_out / tp result against a cycle-free model of the unit;
// a short table of directed requests comes first, then random sequences of
// command latches, shift bursts, time loads, test counting and noise
// ----------------------------------------------------------------------------
module serial_clock_chip_command_shift_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sccsu_pkg::*;

    // op codes the unit ignores
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    localparam int RAND_ITEMS   = 1400;
    localparam int SLOW_RUN     = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic dout;
        logic tp;
    } levels_t;

    typedef struct packed {
        logic [3:0] op;
        logic       val;
        logic       known;
        logic       dout;
        logic       tp;
    } dir_row_t;

    localparam int DIR_N = 25;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{OP_TICK,      1'b0, 1'b1, 1'b0, 1'b0},
        '{OP_UNUSED_HI, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_UNUSED_LO, 1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_OE,        1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_C0,        1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_CS,        1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_STB,       1'b1, 1'b1, 1'b0, 1'b0},
        '{OP_DIN,       1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLK,       1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLK,       1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_STB,       1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CS,        1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CLK,       1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLK,       1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_OE,        1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_CLK,       1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CLK,       1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_C1,        1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_C2,        1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_CS,        1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_STB,       1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,      1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,      1'b1, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,      1'b0, 1'b0, 1'b0, 1'b0},
        '{OP_TICK,      1'b1, 1'b0, 1'b0, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] op;
    logic       value;
    logic       out_valid;
    logic       out_ready;
    logic       data_out;
    logic       tp;

    serial_clock_chip_command_shift_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .tp        (tp)
    );

    // model state of the unit
    logic [39:0] time_bits;
    logic [39:0] shift_bits;
    logic [2:0]  cur_mode;
    logic [2:0]  next_cmd;
    logic [4:0]  pins;
    logic        dout_lvl;
    logic        tp_lvl;
    logic        tp_on;
    logic [1:0]  tp_sel;
    int          tp_ph;
    logic        wave_on;
    logic        wave_fast;
    int          wave_ph;
    logic [1:0]  test_ph;

    // expected pin levels, oldest first
    levels_t level_q[$];
    levels_t want_lv;

    int   cycle_n;
    int   sent_n;
    int   results_n;
    int   mismatch_n;
    int   shift_edges;
    int   test_counts;
    logic [7:0] modes_seen;
    bit   send_quiet;
    bit   sink_quiet;
    bit   hold_done;
    bit   random_part;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // tp half period in ticks for a rate select
    function automatic int tp_half_period(input logic [1:0] sel);
        case (sel)
            TP_SEL_64:   return 32;
            TP_SEL_32:   return 64;
            TP_SEL_256:  return 8;
            default:     return 1;
        endcase
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic void restart_tp(input logic [1:0] sel);
        tp_on  = 1'b1;
        tp_sel = sel;
        tp_ph  = 0;
    endfunction

    function automatic void restart_wave(input logic fast);
        wave_on   = 1'b1;
        wave_fast = fast;
        wave_ph   = 0;
    endfunction

    // command latch sets up outputs and dividers
    function automatic void latch_cmd();
        cur_mode = next_cmd;
        modes_seen[cur_mode] = 1'b1;
        case (cur_mode)
            MODE_HOLD:
            begin
                dout_lvl = 1'b1;
                restart_wave(1'b0);
                restart_tp(TP_SEL_64);
            end
            MODE_SERIAL:
            begin
                wave_on  = 1'b0;
                dout_lvl = shift_bits[0];
                restart_tp(TP_SEL_32);
            end
            MODE_TIME_WR:
            begin
                wave_on   = 1'b0;
                dout_lvl  = shift_bits[0];
                time_bits = shift_bits;
                restart_tp(TP_SEL_32);
            end
            MODE_TIME_RD:
            begin
                shift_bits = time_bits;
                dout_lvl   = 1'b1;
                restart_wave(1'b1);
                restart_tp(TP_SEL_32);
            end
            MODE_TP_64:   restart_tp(TP_SEL_64);
            MODE_TP_256:  restart_tp(TP_SEL_256);
            MODE_TP_2048: restart_tp(TP_SEL_2048);
            default:
            begin
                wave_on = 1'b0;
                test_ph = 2'd0;
            end
        endcase
    endfunction

    // test counter step: 40-bit carry with oe high, bytewise with oe low
    function automatic void test_step();
        test_counts++;
        if (pins[PIN_OE])
        begin
            dout_lvl  = (time_bits[39:32] == 8'd0);
            time_bits = time_bits + 40'd1;
        end
        else
        begin
            for (int i = 0; i < 5; i++)
                time_bits[8*i +: 8] = time_bits[8*i +: 8] + 8'd1;
            dout_lvl = (time_bits[39:32] == 8'd0);
        end
    endfunction

    function automatic void time_tick();
        if (tp_on)
        begin
            tp_ph++;
            if (tp_ph >= tp_half_period(tp_sel))
            begin
                tp_ph  = 0;
                tp_lvl = ~tp_lvl;
            end
        end
        if (wave_on)
        begin
            wave_ph++;
            if (wave_ph >= int'(wave_fast ? PULSE_FAST_LIMIT : PULSE_SLOW_LIMIT))
            begin
                wave_ph  = 0;
                dout_lvl = ~dout_lvl;
            end
        end
        if (cur_mode == MODE_CNT_TEST)
        begin
            test_ph = test_ph + 2'd1;
            if (test_ph == 2'd0)
                test_step();
        end
    endfunction

    // apply one request to the model and return the pin levels after it
    function automatic levels_t predict_levels(input logic [3:0] o, input logic v);
        levels_t lv;
        case (o)
            OP_OE:  pins[PIN_OE] = v;
            OP_CS:  pins[PIN_CS] = v;
            OP_STB:
            begin
                pins[PIN_STB] = v;
                if (pins[PIN_CS] && pins[PIN_STB] && !pins[PIN_CLK])
                    latch_cmd();
            end
            OP_CLK:
            begin
                if (!pins[PIN_CLK] && v && cur_mode == MODE_SERIAL)
                begin
                    shift_bits = {pins[PIN_DIN], shift_bits[39:1]};
                    shift_edges++;
                    if (pins[PIN_OE])
                        dout_lvl = shift_bits[0];
                end
                pins[PIN_CLK] = v;
            end
            OP_C0:   next_cmd[0] = v;
            OP_C1:   next_cmd[1] = v;
            OP_C2:   next_cmd[2] = v;
            OP_DIN:  pins[PIN_DIN] = v;
            OP_TICK: time_tick();
            default: ;
        endcase
        lv.dout = dout_lvl;
        lv.tp   = tp_lvl;
        return lv;
    endfunction

    // offer one request, wait for it to be taken, then idle at random
    task automatic send(input logic [3:0] o, input logic v,
                        input bit fixed = 1'b0, input levels_t fixed_lv = '0);
        levels_t lv;
        int g;
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lv = predict_levels(o, v);
        level_q.push_back(fixed ? fixed_lv : lv);
        sent_n++;
        g = send_quiet ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // well-formed command latch: command bits, clock low, cs high, strobe rise
    task automatic latch_mode(input logic [2:0] m);
        send(OP_C0, m[0]);
        send(OP_C1, m[1]);
        send(OP_C2, m[2]);
        send(OP_CLK, 1'b0);
        send(OP_CS, 1'b1);
        send(OP_STB, 1'b0);
        send(OP_STB, 1'b1);
    endtask

    // clock n bits of a word in, bit 0 first
    task automatic shift_word(input logic [39:0] w, input int n);
        for (int i = 0; i < n; i++)
        begin
            send(OP_DIN, w[i]);
            send(OP_CLK, 1'b1);
            send(OP_CLK, 1'b0);
        end
    endtask

    task automatic tick_run(input int n);
        for (int i = 0; i < n; i++)
            send(OP_TICK, 1'($urandom_range(1)));
    endtask

    function automatic logic [39:0] pick_word();
        case ($urandom_range(4))
            0: return {40{1'b1}};
            1: return {8'h00, {32{1'b1}}};
            2: return {8'($urandom_range(255)), 8'hff, 8'hff, 8'hff, 8'hff};
            3: return 40'd0;
            default: return {8'($urandom), $urandom};
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_n++;
            if (level_q.size() == 0)
            begin
                $display("%0t: result with no request waiting: data_out %0b tp %0b",
                         $time, data_out, tp);
                mismatch_n++;
            end
            else
            begin
                want_lv = level_q.pop_front();
                if (want_lv.dout !== data_out)
                begin
                    $display("%0t: data_out mismatch: expected %0b, actual %0b",
                             $time, want_lv.dout, data_out);
                    mismatch_n++;
                end
                if (want_lv.tp !== tp)
                begin
                    $display("%0t: tp mismatch: expected %0b, actual %0b",
                             $time, want_lv.tp, tp);
                    mismatch_n++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, level_q.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int stall_left;
        int g;
        stall_left = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (($urandom & 32'hff) == 0)
                sink_quiet = !sink_quiet;
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (random_part && !hold_done && results_n >= 300)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (sink_quiet)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    stall_left = g - 1;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int goal;
        int r;
        levels_t lv;
        dir_row_t row;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = OP_OE;
        value    = 1'b0;
        cycle_n = 0; sent_n = 0; results_n = 0; mismatch_n = 0;
        shift_edges = 0; test_counts = 0; modes_seen = '0;
        send_quiet = 1'b0; sink_quiet = 1'b0; hold_done = 1'b0; random_part = 1'b0;

        // model reset
        time_bits = '0; shift_bits = '0; cur_mode = MODE_HOLD; next_cmd = MODE_HOLD;
        pins = '0; dout_lvl = 1'b0; tp_lvl = 1'b0; tp_on = 1'b0; tp_sel = TP_SEL_64;
        tp_ph = 0; wave_on = 1'b0; wave_fast = 1'b0; wave_ph = 0; test_ph = 2'd0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            lv.dout = row.dout;
            lv.tp   = row.tp;
            send(row.op, row.val, row.known, lv);
        end

        // hold mode: 64 Hz tp wave toggling, slow data-out divider counting
        random_part = 1'b1;
        latch_mode(MODE_HOLD);
        send_quiet = 1'b1;
        tick_run(SLOW_RUN);
        send_quiet = 1'b0;

        goal = sent_n + RAND_ITEMS;
        while (sent_n < goal)
        begin
            send_quiet = ($urandom_range(4) == 0);
            r = $urandom_range(99);
            if (r < 16)
            begin
                latch_mode(3'($urandom_range(7)));
            end
            else if (r < 34)
            begin
                // shift burst, sometimes without chip-select or with oe low
                if (cur_mode != MODE_SERIAL || $urandom_range(1))
                    latch_mode(MODE_SERIAL);
                send(OP_OE, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0)
                    send(OP_CS, 1'b0);
                shift_word(pick_word(), $urandom_range(48, 1));
            end
            else if (r < 48)
            begin
                // load the time counter and run the test counter on it
                latch_mode(MODE_SERIAL);
                shift_word(pick_word(), 40);
                latch_mode(MODE_TIME_WR);
                send(OP_OE, 1'($urandom_range(1)));
                latch_mode(MODE_CNT_TEST);
                tick_run(4 * $urandom_range(6, 1) + $urandom_range(3));
            end
            else if (r < 58)
            begin
                // read time into the shift register and clock it out
                latch_mode(MODE_TIME_RD);
                tick_run($urandom_range(20, 1));
                latch_mode(MODE_SERIAL);
                send(OP_OE, 1'b1);
                shift_word(pick_word(), $urandom_range(40, 1));
            end
            else if (r < 76)
            begin
                tick_run($urandom_range(70, 1));
            end
            else if (r < 90)
            begin
                // noise over the whole op field
                repeat ($urandom_range(6, 1))
                    send(4'($urandom_range(15)), 1'($urandom_range(1)));
            end
            else
            begin
                // strobe while clock is high or chip-select is low: no latch
                send(OP_C0, 1'($urandom_range(1)));
                if ($urandom_range(1))
                begin
                    send(OP_CS, 1'b1);
                    send(OP_CLK, 1'b1);
                end
                else
                begin
                    send(OP_CLK, 1'b0);
                    send(OP_CS, 1'b0);
                end
                send(OP_STB, 1'b0);
                send(OP_STB, 1'b1);
                send(OP_CLK, 1'b0);
                tick_run($urandom_range(8, 1));
            end
        end
        send_quiet = 1'b0;
        in_valid <= 1'b0;

        while (level_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests, %0d results, modes latched %b",
                 sent_n, results_n, modes_seen);
        $display("%0d shift edges and %0d test-counter steps in the model",
                 shift_edges, test_counts);
        if (mismatch_n == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sccsu_pkg.sv
rtl/core/sccsu_test_count.sv
rtl/core/serial_clock_chip_command_shift_unit.sv
bench/serial_clock_chip_command_shift_unit_tb.sv
